>>> design/bds_pkg.sv
// Package for the 2x2 box downscaler: sizes, register indexes and the
// operation record passed from the front end to the back end.
// No dependencies.
package bds_pkg;

   localparam int MAX_WIDTH      = 4096;
   localparam int MAX_HEIGHT     = 4096;
   localparam int LINE_DEPTH     = MAX_WIDTH / 2;
   localparam int LINE_ADDR_BITS = $clog2(LINE_DEPTH);
   localparam int COUNT_BITS     = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT);

   localparam int SIZE_BITS  = 13;
   localparam int PIXEL_BITS = 8;
   localparam int PAIR_BITS  = PIXEL_BITS + 1;
   localparam int SUM_BITS   = PIXEL_BITS + 2;

   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS  = QUEUE_PTR_BITS + 1;

   localparam logic [SIZE_BITS-1:0] MIN_SIZE       = SIZE_BITS'(2);
   localparam logic [SIZE_BITS-1:0] MAX_WIDTH_SIZE = SIZE_BITS'(MAX_WIDTH);
   localparam logic [SIZE_BITS-1:0] MAX_HEIGHT_SIZE = SIZE_BITS'(MAX_HEIGHT);
   localparam logic [SIZE_BITS-1:0] RESET_WIDTH    = SIZE_BITS'(640);
   localparam logic [SIZE_BITS-1:0] RESET_HEIGHT   = SIZE_BITS'(480);

   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   typedef enum logic {
      OP_STORE,
      OP_EMIT
   } op_kind_type;

   typedef struct packed {
      op_kind_type                kind;
      logic [LINE_ADDR_BITS-1:0]  addr;
      logic [PAIR_BITS-1:0]       pair;
      logic                       row_last;
      logic                       frame_last;
   } op_type;

   // Frame sizes outside the legal range are pinned to its nearest end.
   function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] value,
                                                       input logic [SIZE_BITS-1:0] limit);
      logic [SIZE_BITS-1:0] result;
      result = value;
      if (value < MIN_SIZE) begin
         result = MIN_SIZE;
      end else if (value > limit) begin
         result = limit;
      end
      return result;
   endfunction

endpackage

>>> design/bds_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued. No dependencies.
module bds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/bds_front.sv
// Front end of the box downscaler: pixel intake, frame counters, size
// registers and pair sums. Depends on bds_pkg.
module bds_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bds_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bds_pkg::SIZE_BITS-1:0]       csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bds_pkg::PIXEL_BITS-1:0]      req_pixel_in,
   input  logic                                queue_full,
   output logic                                op_push,
   output bds_pkg::op_type                     op_data
);

   logic [bds_pkg::SIZE_BITS-1:0]  width_ff, width_in;
   logic [bds_pkg::SIZE_BITS-1:0]  height_ff, height_in;
   logic [bds_pkg::COUNT_BITS-1:0] col_ff, col_in;
   logic [bds_pkg::COUNT_BITS-1:0] row_ff, row_in;
   logic [bds_pkg::PIXEL_BITS-1:0] held_ff, held_in;

   logic                           accept;
   logic [bds_pkg::SIZE_BITS-1:0]  col_ext, row_ext;
   logic [bds_pkg::SIZE_BITS-1:0]  col_plus, row_plus;
   logic [bds_pkg::SIZE_BITS-1:0]  width_even, height_even;
   logic                           in_frame;
   logic                           row_last;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   assign col_ext     = {1'b0, col_ff};
   assign row_ext     = {1'b0, row_ff};
   assign col_plus    = col_ext + 1'b1;
   assign row_plus    = row_ext + 1'b1;
   assign width_even  = {width_ff[bds_pkg::SIZE_BITS-1:1], 1'b0};
   assign height_even = {height_ff[bds_pkg::SIZE_BITS-1:1], 1'b0};
   assign in_frame    = (col_ext < width_even) && (row_ext < height_even);
   assign row_last    = (col_ext == width_even - 1'b1);

   // Only the second pixel of a pair inside the even-sized frame makes work.
   assign op_push            = accept && in_frame && col_ff[0];
   assign op_data.kind       = row_ff[0] ? bds_pkg::OP_EMIT : bds_pkg::OP_STORE;
   assign op_data.addr       = col_ff[bds_pkg::COUNT_BITS-1:1];
   assign op_data.pair       = {1'b0, held_ff} + {1'b0, req_pixel_in};
   assign op_data.row_last   = row_last;
   assign op_data.frame_last = row_last && (row_ext == height_even - 1'b1);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      held_in   = held_ff;
      if (csr_we) begin
         case (csr_index)
            bds_pkg::CSR_IMAGE_WIDTH: begin
               width_in = bds_pkg::clamp_size(csr_wdata, bds_pkg::MAX_WIDTH_SIZE);
            end
            bds_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = bds_pkg::clamp_size(csr_wdata, bds_pkg::MAX_HEIGHT_SIZE);
            end
            default: begin
            end
         endcase
      end
      if (accept) begin
         if (in_frame && !col_ff[0]) begin
            held_in = req_pixel_in;
         end
         if (col_plus >= width_ff) begin
            col_in = '0;
            row_in = (row_plus >= height_ff) ? '0 : row_plus[bds_pkg::COUNT_BITS-1:0];
         end else begin
            col_in = col_plus[bds_pkg::COUNT_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bds_pkg::RESET_WIDTH;
         height_ff <= bds_pkg::RESET_HEIGHT;
         col_ff    <= '0;
         row_ff    <= '0;
         held_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         held_ff   <= held_in;
      end
   end

endmodule

>>> design/bds_fifo.sv
// Short operation queue between the front and back ends of the box
// downscaler. Depends on bds_pkg.
module bds_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bds_pkg::op_type  push_data,
   output logic             full,
   input  logic             pop,
   output bds_pkg::op_type  pop_data,
   output logic             not_empty
);

   bds_pkg::op_type entries_ff [bds_pkg::QUEUE_DEPTH];

   logic [bds_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bds_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [bds_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;

   assign full      = (count_ff == bds_pkg::QUEUE_CNT_BITS'(bds_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("operation queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> not_empty)
      else $error("operation queue read while empty");
`endif

endmodule

>>> design/bds_back.sv
// Back end of the box downscaler: line buffer access, block sum and the
// result register. Depends on bds_pkg and bds_ram.
module bds_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            op_valid,
   input  bds_pkg::op_type                 op_data,
   output logic                            op_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bds_pkg::PIXEL_BITS-1:0]  rsp_pixel_out,
   output logic                            rsp_row_last,
   output logic                            rsp_frame_last
);

   logic                           wr_en, rd_en;
   logic [bds_pkg::PAIR_BITS-1:0]  rd_data;
   logic [bds_pkg::SUM_BITS-1:0]   block_sum;
   logic                           out_free, s1_free;

   // Stage one: waits for the stored pair sum from the line buffer.
   logic                           s1_valid_ff, s1_valid_in;
   logic [bds_pkg::PAIR_BITS-1:0]  s1_pair_ff;
   logic                           s1_row_last_ff;
   logic                           s1_frame_last_ff;

   // Result register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [bds_pkg::PIXEL_BITS-1:0] rsp_pixel_ff;
   logic                           rsp_row_last_ff;
   logic                           rsp_frame_last_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s1_free  = !s1_valid_ff || out_free;

   // Stores never wait on the result side; averages need room in stage one.
   assign op_pop = op_valid && ((op_data.kind == bds_pkg::OP_STORE) || s1_free);
   assign wr_en  = op_pop && (op_data.kind == bds_pkg::OP_STORE);
   assign rd_en  = op_pop && (op_data.kind == bds_pkg::OP_EMIT);

   bds_ram #(
      .WIDTH (bds_pkg::PAIR_BITS),
      .DEPTH (bds_pkg::LINE_DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (op_data.addr),
      .wr_data (op_data.pair),
      .rd_en   (rd_en),
      .rd_addr (op_data.addr),
      .rd_data (rd_data)
   );

   assign block_sum = {1'b0, rd_data} + {1'b0, s1_pair_ff};

   always_comb begin
      s1_valid_in  = s1_free ? rd_en : s1_valid_ff;
      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_pair_ff       <= op_data.pair;
         s1_row_last_ff   <= op_data.row_last;
         s1_frame_last_ff <= op_data.frame_last;
      end
      if (s1_valid_ff && out_free) begin
         rsp_pixel_ff      <= block_sum[bds_pkg::SUM_BITS-1:2];
         rsp_row_last_ff   <= s1_row_last_ff;
         rsp_frame_last_ff <= s1_frame_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_row_last   = rsp_row_last_ff;
   assign rsp_frame_last = rsp_frame_last_ff;

`ifndef SYNTHESIS
   a_frame_ends_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_frame_last_ff |-> rsp_row_last_ff)
      else $error("frame end flagged without row end");
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(rd_data))
      else $error("stalled block sum lost its line buffer data");
`endif

endmodule

>>> design/box_downscale_2x2.sv
// Top level of the 2x2 box-filter downsampler for 8-bit grayscale frames.
// Depends on bds_pkg, bds_front, bds_fifo and bds_back.
//
//   Channel  Direction  Ports                                    Moves
//   req      in         req_valid/req_ready, req_pixel_in        one input pixel
//   rsp      out        rsp_valid/rsp_ready, rsp_pixel_out,      one output pixel
//                       rsp_row_last, rsp_frame_last
//   csr      in         csr_we, csr_index, csr_wdata             one size register
//
// One pixel transfer is taken every cycle while the operation queue has room;
// the output side also sustains one transfer per cycle while rsp_ready is high.
// A pixel that closes a 2x2 block passes the queue, the line buffer read
// and the result register before it appears on rsp.
// Pixels on even rows only update the line buffer and give no result.
// Reset (synchronous) empties the queue and pipeline, zeroes the frame
// counters and loads 640 x 480; the line buffer is not cleared.
// A stalled rsp fills the result register, stage one and then the four-entry
// queue; req_ready drops only when that queue is full.
module box_downscale_2x2 (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bds_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bds_pkg::SIZE_BITS-1:0]       csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bds_pkg::PIXEL_BITS-1:0]      req_pixel_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bds_pkg::PIXEL_BITS-1:0]      rsp_pixel_out,
   output logic                                rsp_row_last,
   output logic                                rsp_frame_last
);

   logic            queue_full;
   logic            op_push;
   bds_pkg::op_type op_in;
   logic            op_valid;
   logic            op_pop;
   bds_pkg::op_type op_out;

   // The front end counts columns and rows, holds the first pixel of each
   // horizontal pair and turns the second one into a store or average request.
   bds_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_pixel_in (req_pixel_in),
      .queue_full   (queue_full),
      .op_push      (op_push),
      .op_data      (op_in)
   );

   // The queue lets intake continue while the result side is stalled.
   bds_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (op_in),
      .full      (queue_full),
      .pop       (op_pop),
      .pop_data  (op_out),
      .not_empty (op_valid)
   );

   // The back end owns the line buffer: stores write a pair sum, averages
   // read the sum from the row above and add the new pair to it.
   bds_back u_back (
      .clock          (clock),
      .reset          (reset),
      .op_valid       (op_valid),
      .op_data        (op_out),
      .op_pop         (op_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_row_last   (rsp_row_last),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

>>> test/box_downscale_2x2_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the 2x2 box-filter downsampler box_downscale_2x2.
// Depends on bds_pkg for sizes and register indexes, and on the block itself.
module box_downscale_2x2_tb;

   // Widths taken from the package, used in declarations and size casts.
   localparam int PIXEL_BITS = bds_pkg::PIXEL_BITS;
   localparam int SIZE_BITS  = bds_pkg::SIZE_BITS;
   localparam int PAIR_BITS  = bds_pkg::PAIR_BITS;
   localparam int SUM_BITS   = bds_pkg::SUM_BITS;

   // One output pixel with its row and frame markers, as the block emits it.
   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic                  row_last;
      logic                  frame_last;
   } downscaled_pixel_type;

   // The run is stopped here whatever state it is in. This leaves a wide
   // margin over the length of a correct run.
   localparam int CYCLE_LIMIT     = 1_000_000;
   // Pixels on even rows give no output but still travel through the queue
   // and the line buffer write. This covers them with room.
   localparam int DRAIN_CYCLES    = 10;
   // Length of the long output stall that fills the block and stalls its input.
   localparam int HOLD_OFF_CYCLES = 150;

   logic                               clock;
   logic                               reset;
   logic                               csr_we;
   logic [bds_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [SIZE_BITS-1:0]               csr_wdata;
   logic                               req_valid;
   logic                               req_ready;
   logic [PIXEL_BITS-1:0]              req_pixel_in;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic [PIXEL_BITS-1:0]              rsp_pixel_out;
   logic                               rsp_row_last;
   logic                               rsp_frame_last;

   box_downscale_2x2 dut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_row_last   (rsp_row_last),
      .rsp_frame_last (rsp_frame_last)
   );

   // Shadow copy of the block's registers and frame state, kept in step with
   // every accepted pixel transfer and register write.
   logic [SIZE_BITS-1:0]  width_setting  = bds_pkg::RESET_WIDTH;
   logic [SIZE_BITS-1:0]  height_setting = bds_pkg::RESET_HEIGHT;
   logic [PAIR_BITS-1:0]  pair_line [bds_pkg::LINE_DEPTH];
   logic [PIXEL_BITS-1:0] held_pixel = '0;
   int                    col_pos = 0;
   int                    row_pos = 0;

   // Output pixels that the block still owes, oldest first.
   downscaled_pixel_type expected_pixels[$];

   int error_count  = 0;
   int cycle_count  = 0;
   int pixels_sent  = 0;

   // Idle rates in percent for the two sides of the block.
   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;

   // The test sequence asks for a long output stall by bumping the request
   // count; the receiver process notices the change and counts the stall out.
   int hold_off_requested = 0;
   int hold_off_served    = 0;
   int hold_off_left      = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A frame size register below two or above the maximum is pinned to the
   // nearest legal size.
   function automatic int limit_size(input logic [SIZE_BITS-1:0] setting, input int upper);
      int v;
      v = int'(setting);
      if (v < 2) begin
         return 2;
      end
      return (v > upper) ? upper : v;
   endfunction

   // Mostly uniform pixel values, with the two extremes a little more often.
   function automatic logic [PIXEL_BITS-1:0] random_pixel();
      case ($urandom_range(0, 9))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         default: begin
            return PIXEL_BITS'($urandom_range(0, 255));
         end
      endcase
   endfunction

   // Fixed pattern for the first two rows: every eighth column starts a block
   // of all 255, followed by a block whose sum is three.
   function automatic logic [PIXEL_BITS-1:0] pattern_pixel(input int r, input int c);
      case (c % 8)
         0, 1: begin
            return 8'd255;
         end
         2: begin
            return (r == 1) ? 8'd0 : 8'd1;
         end
         3: begin
            return 8'd1;
         end
         default: begin
            return random_pixel();
         end
      endcase
   endfunction

   // Advances the shadow state by one accepted pixel. On even rows the sum of
   // each horizontal pair goes to the line store; on odd rows the new pair sum
   // is added to the stored one and a quarter of the total is expected out.
   // A trailing odd column or row is consumed without output; a column counter
   // left beyond a shrunken frame wraps at the next pixel, a row one at row end.
   task automatic downscale_pixel(input logic [PIXEL_BITS-1:0] pix);
      int                    w;
      int                    h;
      int                    w_even;
      int                    h_even;
      logic [PAIR_BITS-1:0]  pair;
      logic [SUM_BITS-1:0]   sum;
      downscaled_pixel_type  result;
      w      = limit_size(width_setting, bds_pkg::MAX_WIDTH);
      h      = limit_size(height_setting, bds_pkg::MAX_HEIGHT);
      w_even = w - (w % 2);
      h_even = h - (h % 2);
      if (col_pos < w_even && row_pos < h_even) begin
         if (col_pos % 2 == 0) begin
            held_pixel = pix;
         end else begin
            pair = PAIR_BITS'(held_pixel) + PAIR_BITS'(pix);
            if (row_pos % 2 == 0) begin
               pair_line[col_pos / 2] = pair;
            end else begin
               sum = SUM_BITS'(pair_line[col_pos / 2]) + SUM_BITS'(pair);
               result.pixel      = sum[SUM_BITS-1:2];
               result.row_last   = (col_pos == w_even - 1);
               result.frame_last = result.row_last && (row_pos == h_even - 1);
               expected_pixels.push_back(result);
            end
         end
      end
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endtask

   // Offers one pixel, after a random number of idle cycles, and holds it
   // until the transfer happens. The shadow state moves on at that edge.
   task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= pix;
      do begin
         @(posedge clock);
      end while (!req_ready);
      downscale_pixel(pix);
      pixels_sent++;
   endtask

   // Sends random pixels until the frame counters are back at the top left
   // corner. From there this is one whole frame; from the middle of a frame
   // it completes that frame under the current sizes.
   task automatic stream_frame();
      do begin
         send_pixel(random_pixel());
      end while (col_pos != 0 || row_pos != 0);
   endtask

   // Stops offering pixels and waits until every owed output has come, then
   // waits out DRAIN_CYCLES so that pixels with no output have left the pipeline.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the width register and then the height register, back to back.
   // Only called while the block is idle.
   task automatic write_sizes(input logic [SIZE_BITS-1:0] w, input logic [SIZE_BITS-1:0] h);
      csr_we    <= 1'b1;
      csr_index <= bds_pkg::CSR_IMAGE_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      width_setting = w;
      csr_index <= bds_pkg::CSR_IMAGE_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      height_setting = h;
      csr_we <= 1'b0;
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      sender_idle_pct   = sender_pct;
      receiver_idle_pct = receiver_pct;
   endtask

   // The sizes loaded by reset, 640 x 480, carry the first 48 pixels of the
   // first row, which would have wrapped under a width of 48 or less. A width of
   // eight written mid-row then wraps the counters at the next pixel, and the
   // second row reads the stored pair sums. The pattern gives the largest
   // block (all 255) and a block whose sum is three, which must floor to zero.
   task automatic test_reset_sizes();
      for (int c = 0; c < 48; c++) begin
         send_pixel(pattern_pixel(0, c));
      end
      wait_for_idle();
      write_sizes(13'd8, bds_pkg::RESET_HEIGHT);
      send_pixel(random_pixel());
      for (int c = 0; c < 8; c++) begin
         send_pixel(pattern_pixel(1, c));
      end
      wait_for_idle();
   endtask

   // Out-of-range sizes at both ends. The first write lands with the row
   // counter at two, past the new last row of a 2 x 2 frame, so that row is
   // consumed without output before the frame wraps. Sizes above the maximum
   // are pinned to 4096: a long start of the first row runs without a wrap,
   // and a narrow width written mid-row then closes it and reads it back.
   task automatic test_size_limits();
      write_sizes(13'd1, 13'd0);
      repeat (3) stream_frame();
      wait_for_idle();
      write_sizes(13'd8191, 13'd4097);
      repeat (24) send_pixel(random_pixel());
      wait_for_idle();
      write_sizes(13'd6, 13'd4097);
      repeat (7) send_pixel(random_pixel());
      wait_for_idle();
   endtask

   // Odd sizes drop the last column and row; 2 x 2 is the smallest frame,
   // whose only output pixel ends both its row and the frame. The first
   // frame only finishes the row left over from the tall frame before.
   task automatic test_odd_and_smallest();
      write_sizes(13'd5, 13'd3);
      repeat (3) stream_frame();
      wait_for_idle();
      write_sizes(13'd3, 13'd6);
      stream_frame();
      wait_for_idle();
      write_sizes(13'd2, 13'd2);
      repeat (3) stream_frame();
      wait_for_idle();
   endtask

   // Sizes changed in the middle of a frame: the counters keep going, and
   // the row counter, now beyond the new last row, wraps at the next row end.
   task automatic test_mid_frame_resize();
      write_sizes(13'd8, 13'd6);
      repeat (27) send_pixel(random_pixel());
      wait_for_idle();
      write_sizes(13'd4, 13'd2);
      stream_frame();
      stream_frame();
      wait_for_idle();
   endtask

   // The receiver holds off for a long stretch while pixels keep coming, so
   // the result register, the pipeline and the queue fill and the input
   // stalls.
   task automatic test_output_stall();
      write_sizes(13'd16, 13'd4);
      hold_off_requested++;
      stream_frame();
      wait_for_idle();
   endtask

   // The sender stops in the middle of a frame until every output owed so
   // far has arrived, then finishes the frame.
   task automatic test_sender_pause();
      write_sizes(13'd10, 13'd6);
      repeat (35) send_pixel(random_pixel());
      wait_for_idle();
      stream_frame();
      wait_for_idle();
   endtask

   // Random sizes, mostly small, a few below the legal minimum. Each setting
   // runs one or two frames; now and then up to twenty more pixels follow
   // so that the next setting can take effect in the middle of a frame.
   task automatic test_random_frames(input int pixel_count);
      int                   start_count;
      logic [SIZE_BITS-1:0] w;
      logic [SIZE_BITS-1:0] h;
      start_count = pixels_sent;
      while (pixels_sent - start_count < pixel_count) begin
         w = ($urandom_range(0, 9) == 0) ? SIZE_BITS'($urandom_range(0, 1))
                                         : SIZE_BITS'($urandom_range(2, 12));
         h = ($urandom_range(0, 9) == 0) ? SIZE_BITS'($urandom_range(0, 1))
                                         : SIZE_BITS'($urandom_range(2, 8));
         write_sizes(w, h);
         repeat ($urandom_range(1, 2)) stream_frame();
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 20)) send_pixel(random_pixel());
         end
         wait_for_idle();
      end
   endtask

   // Receiver: takes output transfers at a random rate, except during a
   // requested long stall, which it counts out itself.
   always @(posedge clock) begin
      if (hold_off_served != hold_off_requested) begin
         hold_off_served = hold_off_requested;
         hold_off_left   = HOLD_OFF_CYCLES;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // Checker: every output transfer is compared field by field with the
   // oldest owed pixel.
   always @(posedge clock) begin
      downscaled_pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            error_count++;
            $display("%0t: output pixel %0d with none expected", $time, rsp_pixel_out);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_pixel_out !== want.pixel) begin
               error_count++;
               $display("%0t: pixel_out expected %0d, got %0d",
                        $time, want.pixel, rsp_pixel_out);
            end
            if (rsp_row_last !== want.row_last) begin
               error_count++;
               $display("%0t: row_last expected %0b, got %0b",
                        $time, want.row_last, rsp_row_last);
            end
            if (rsp_frame_last !== want.frame_last) begin
               error_count++;
               $display("%0t: frame_last expected %0b, got %0b",
                        $time, want.frame_last, rsp_frame_last);
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("box_downscale_2x2 test failed");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = bds_pkg::CSR_IMAGE_WIDTH;
      csr_wdata    = '0;
      req_valid    = 1'b0;
      req_pixel_in = '0;
      rsp_ready    = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with the sender idling lightly and the receiver often.
      set_idling(37, 75);
      test_reset_sizes();
      test_size_limits();
      test_odd_and_smallest();
      test_mid_frame_resize();
      test_output_stall();
      test_sender_pause();

      // Random part in three stretches: slow receiver, slow sender, no idling.
      test_random_frames(50);
      set_idling(75, 37);
      test_random_frames(50);
      set_idling(0, 0);
      test_random_frames(50);

      wait_for_idle();
      if (error_count == 0) begin
         $display("box_downscale_2x2 test passed");
      end else begin
         $display("box_downscale_2x2 test failed");
      end
      $finish;
   end

endmodule
